// ===== rtl/caid_pkg.sv =====
package caid_pkg;

    localparam int CODE_LENGTH = 1023;
    localparam int LAST_CHIP   = 1022;
    localparam int CHIP_BITS   = 10;
    localparam int PERIOD_BITS = 7;
    localparam int CMD_BITS    = 2;

    localparam int DEF_SAMPLE_BITS     = 12;
    localparam int DEF_SUM_BITS        = 40;
    localparam int DEF_PHASE_FRAC_BITS = 32;

    typedef logic [CMD_BITS-1:0]    cmd_t;
    typedef logic [CHIP_BITS-1:0]   chip_t;
    typedef logic [PERIOD_BITS-1:0] period_t;

    localparam cmd_t CMD_SAMPLE = 2'd0;
    localparam cmd_t CMD_DUMP   = 2'd1;
    localparam cmd_t CMD_LOAD   = 2'd2;

endpackage

// ===== rtl/caid_ram.sv =====
module caid_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1023,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ca_code_integrate_and_dump_unit.sv =====
// Spreading-code correlator with integrate-and-dump.
// Input stream (s_axis_*): tuser carries the command (sample, dump, load chip); tdata carries
// the sample pair, the per-sample code phase step and the chip index and value for loads.
// Output stream (m_axis_*): one transaction per dump, and one per sample that completes the
// configured number of code periods; tuser is set for a full integration, clear for a
// partial sum returned by a dump.
// Configuration (cfg_*): integration_periods, always ready; write only while the block is idle.
// A result passes the stage 1, stage 2 and output registers before it appears on m_axis.
// Throughput: one input transaction per cycle while s_axis_tready is high, set by the phase
// accumulator (one add and one compare-subtract per sample) and the registered code RAM read.
// Pipeline: phase update on acceptance, chip rounding and code RAM access, then accumulate.
// Loads write the code RAM in the same stage that samples read it, so order is kept.
// Reset clears the phase, the period count, the running and held sums and the output stage;
// integration_periods returns to 1. The code RAM holds nothing until chips are loaded.
// When the receiver stalls, an output register and a skid register take up to two results;
// s_axis_tready falls only once the skid register is occupied, and the pipeline then holds.
module ca_code_integrate_and_dump_unit
    import caid_pkg::*;
#(
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int SUM_BITS        = DEF_SUM_BITS,
    parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS,
    localparam int STEP_BITS      = PHASE_FRAC_BITS + 4,
    localparam int IN_BITS        = 2 * SAMPLE_BITS + STEP_BITS + CHIP_BITS + 1,
    localparam int IN_DATA_BITS   = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS       = 2 * SUM_BITS + PERIOD_BITS,
    localparam int OUT_DATA_BITS  = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [PERIOD_BITS-1:0]   cfg_data,        // integration_periods

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // sample_i, sample_q, phase_step, code_index, code_bit, zero padding
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    input  logic [CMD_BITS-1:0]      s_axis_tuser,    // command

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // sum_i, sum_q, periods_done, zero padding
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                     m_axis_tuser     // complete
);

    localparam int Q_LSB      = SAMPLE_BITS;
    localparam int STEP_LSB   = 2 * SAMPLE_BITS;
    localparam int IDX_LSB    = STEP_LSB + STEP_BITS;
    localparam int BIT_LSB    = IDX_LSB + CHIP_BITS;
    localparam int PHASE_BITS = CHIP_BITS + PHASE_FRAC_BITS;
    localparam int PSUM_BITS  = PHASE_BITS + 1;
    localparam int RND_BITS   = CHIP_BITS + 1;

    localparam logic [PSUM_BITS-1:0] PHASE_MOD  = PSUM_BITS'(CODE_LENGTH) << PHASE_FRAC_BITS;
    localparam logic [PSUM_BITS-1:0] PHASE_HALF = PSUM_BITS'(1) << (PHASE_FRAC_BITS - 1);
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0]  a,
        input logic signed [SAMPLE_BITS:0] b
    );
        logic signed [SUM_BITS:0] s;
        s = {a[SUM_BITS-1], a} + {{(SUM_BITS-SAMPLE_BITS){b[SAMPLE_BITS]}}, b};
        if (s[SUM_BITS] != s[SUM_BITS-1])
        begin
            return s[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_BITS-1:0];
    endfunction

    // ---------------------------------------------------------------- control
    logic adv;
    logic in_fire;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    period_t integration_periods_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integration_periods_reg <= period_t'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            integration_periods_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------- phase accumulator
    cmd_t                         in_cmd;
    logic [STEP_BITS-1:0]         in_step;
    logic [PHASE_BITS-1:0]        phase_reg;
    logic [PHASE_BITS-1:0]        phase_next;
    logic [PSUM_BITS-1:0]         phase_sum;
    logic [PSUM_BITS-1:0]         phase_wrap;

    assign in_cmd     = s_axis_tuser;
    assign in_step    = s_axis_tdata[STEP_LSB +: STEP_BITS];
    assign phase_sum  = {1'b0, phase_reg} + PSUM_BITS'(in_step);
    assign phase_wrap = phase_sum - PHASE_MOD;
    assign phase_next = (phase_sum >= PHASE_MOD) ? phase_wrap[PHASE_BITS-1:0]
                                                 : phase_sum[PHASE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (in_fire && in_cmd == CMD_SAMPLE)
        begin
            phase_reg <= phase_next;
        end
    end

    // ---------------------------------------------------------------- stage 1: chip, code RAM
    logic                          s1_valid_reg;
    cmd_t                          s1_cmd_reg;
    logic signed [SAMPLE_BITS-1:0] s1_i_reg;
    logic signed [SAMPLE_BITS-1:0] s1_q_reg;
    chip_t                         s1_idx_reg;
    logic                          s1_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg <= in_cmd;
            s1_i_reg   <= s_axis_tdata[0 +: SAMPLE_BITS];
            s1_q_reg   <= s_axis_tdata[Q_LSB +: SAMPLE_BITS];
            s1_idx_reg <= s_axis_tdata[IDX_LSB +: CHIP_BITS];
            s1_bit_reg <= s_axis_tdata[BIT_LSB];
        end
    end

    logic [PSUM_BITS-1:0] rnd_sum;
    logic [RND_BITS-1:0]  rnd;
    chip_t                chip;
    chip_t                last_chip_reg;
    logic                 chip_wrap;
    logic                 s1_sample;
    logic                 ram_we;
    logic                 ram_rdata;

    // Round to the nearest chip; the top half of the last chip rounds onto chip 0.
    assign rnd_sum   = {1'b0, phase_reg} + PHASE_HALF;
    assign rnd       = rnd_sum[PHASE_FRAC_BITS +: RND_BITS];
    assign chip      = (rnd == RND_BITS'(CODE_LENGTH)) ? '0 : rnd[CHIP_BITS-1:0];
    assign chip_wrap = (last_chip_reg == chip_t'(LAST_CHIP)) && (chip == '0);
    assign s1_sample = s1_valid_reg && s1_cmd_reg == CMD_SAMPLE;
    assign ram_we    = adv && s1_valid_reg && s1_cmd_reg == CMD_LOAD
                       && s1_idx_reg != chip_t'(CODE_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_chip_reg <= '0;
        end
        else if (adv && s1_sample)
        begin
            last_chip_reg <= chip;
        end
    end

    caid_ram #(
        .WIDTH (1),
        .DEPTH (CODE_LENGTH)
    ) u_code_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx_reg),
        .wdata (s1_bit_reg),
        .re    (adv),
        .raddr (chip),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- stage 2: accumulate
    logic                          s2_valid_reg;
    cmd_t                          s2_cmd_reg;
    logic signed [SAMPLE_BITS-1:0] s2_i_reg;
    logic signed [SAMPLE_BITS-1:0] s2_q_reg;
    logic                          s2_wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_i_reg    <= s1_i_reg;
            s2_q_reg    <= s1_q_reg;
            s2_wrap_reg <= s1_sample && chip_wrap;
        end
    end

    logic signed [SUM_BITS-1:0] run_i_reg, run_i_next;
    logic signed [SUM_BITS-1:0] run_q_reg, run_q_next;
    logic signed [SUM_BITS-1:0] held_i_reg, held_i_next;
    logic signed [SUM_BITS-1:0] held_q_reg, held_q_next;
    logic                       held_valid_reg, held_valid_next;
    period_t                    period_count_reg, period_count_next;

    logic                       s2_fire;
    period_t                    eff_periods;
    period_t                    pc_inc;
    logic                       latch;
    logic signed [SAMPLE_BITS:0] term_i;
    logic signed [SAMPLE_BITS:0] term_q;
    logic signed [SUM_BITS-1:0] base_i;
    logic signed [SUM_BITS-1:0] base_q;

    logic                       res_valid;
    logic signed [SUM_BITS-1:0] res_i;
    logic signed [SUM_BITS-1:0] res_q;
    logic                       res_complete;
    period_t                    res_periods;

    assign s2_fire     = adv && s2_valid_reg;
    assign eff_periods = (integration_periods_reg == '0) ? period_t'(1) : integration_periods_reg;
    assign pc_inc      = s2_wrap_reg ? period_count_reg + period_t'(1) : period_count_reg;
    assign latch       = pc_inc >= eff_periods;
    assign base_i      = latch ? '0 : run_i_reg;
    assign base_q      = latch ? '0 : run_q_reg;
    // Code bit 1 keeps the sample, 0 flips it.
    assign term_i      = ram_rdata ? (SAMPLE_BITS+1)'(s2_i_reg) : -(SAMPLE_BITS+1)'(s2_i_reg);
    assign term_q      = ram_rdata ? (SAMPLE_BITS+1)'(s2_q_reg) : -(SAMPLE_BITS+1)'(s2_q_reg);

    always_comb
    begin
        run_i_next        = run_i_reg;
        run_q_next        = run_q_reg;
        held_i_next       = held_i_reg;
        held_q_next       = held_q_reg;
        held_valid_next   = held_valid_reg;
        period_count_next = period_count_reg;
        res_valid         = 1'b0;
        res_i             = run_i_reg;
        res_q             = run_q_reg;
        res_complete      = 1'b1;
        res_periods       = eff_periods;
        if (s2_fire)
        begin
            case (s2_cmd_reg)
                CMD_SAMPLE:
                begin
                    if (latch)
                    begin
                        held_i_next     = run_i_reg;
                        held_q_next     = run_q_reg;
                        held_valid_next = 1'b1;
                        res_valid       = 1'b1;
                    end
                    period_count_next = latch ? '0 : pc_inc;
                    run_i_next        = sat_add(base_i, term_i);
                    run_q_next        = sat_add(base_q, term_q);
                end
                CMD_DUMP:
                begin
                    res_valid = 1'b1;
                    if (held_valid_reg)
                    begin
                        held_valid_next = 1'b0;
                        res_i           = held_i_reg;
                        res_q           = held_q_reg;
                    end
                    else
                    begin
                        res_complete      = 1'b0;
                        res_periods       = period_count_reg;
                        run_i_next        = '0;
                        run_q_next        = '0;
                        period_count_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_i_reg        <= '0;
            run_q_reg        <= '0;
            held_i_reg       <= '0;
            held_q_reg       <= '0;
            held_valid_reg   <= 1'b0;
            period_count_reg <= '0;
        end
        else
        begin
            run_i_reg        <= run_i_next;
            run_q_reg        <= run_q_next;
            held_i_reg       <= held_i_next;
            held_q_reg       <= held_q_next;
            held_valid_reg   <= held_valid_next;
            period_count_reg <= period_count_next;
        end
    end

    // ---------------------------------------------------------------- output and skid
    logic [OUT_DATA_BITS-1:0] res_data;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic                     out_user_reg;
    logic [OUT_DATA_BITS-1:0] skid_data_reg;
    logic                     skid_user_reg;
    logic                     out_free;

    assign res_data = OUT_DATA_BITS'({res_periods, res_q, res_i});
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
            else if (res_valid)
            begin
                out_data_reg <= res_data;
                out_user_reg <= res_complete;
            end
        end
        else if (res_valid)
        begin
            // hold the result aside while the receiver stalls
            skid_data_reg <= res_data;
            skid_user_reg <= res_complete;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ---------------------------------------------------------------- assertions
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register occupied while output register empty");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, phase_reg} < PHASE_MOD)
        else $error("code phase not below one code length");

    a_last_chip_range: assert property (@(posedge clk) disable iff (!rst_n)
        last_chip_reg <= chip_t'(LAST_CHIP))
        else $error("last chip beyond end of code");

    a_held_on_latch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(held_valid_reg) |-> $past(s2_fire && s2_cmd_reg == CMD_SAMPLE && latch))
        else $error("held sum set without a completed integration");

endmodule
